// File: design/macs_pkg.sv
// ----------------------------------------------------------------------------
// macs_pkg
// shared types and constants for the moving average crossover signal block
// ----------------------------------------------------------------------------
package macs_pkg;

  // trade status codes
  typedef enum logic [1:0] {
    SIG_NOT_READY = 2'd0,
    SIG_HOLD      = 2'd1,
    SIG_BUY       = 2'd2,
    SIG_SELL      = 2'd3
  } signal_t;

  // stage load strobes of the constant divider
  typedef struct packed {
    logic ld1;
    logic ld2;
  } cdiv_en_t;

  // levels use p/250 and p/500 (0.4 and 0.2 percent offsets)
  localparam int LVL_DIV = 250;

endpackage

// File: design/macs_cdiv.sv
// ----------------------------------------------------------------------------
// macs_cdiv
// two-stage floor division by a constant: reciprocal multiply, then one
// compare-and-subtract correction
// ----------------------------------------------------------------------------
module macs_cdiv #(
  parameter int XW  = 24,
  parameter int DIV = 5
) (
  input  logic               clk,
  input  macs_pkg::cdiv_en_t en,
  input  logic [XW-1:0]      x,
  output logic [XW-1:0]      q,
  output logic               rem_nz
);

  localparam int RW = $clog2(DIV + 1);
  localparam logic [XW:0]   SCALE = {1'b1, {XW{1'b0}}};
  localparam logic [XW:0]   RECIP = SCALE / (XW + 1)'(DIV);
  localparam logic [XW-1:0] DIV_X = XW'(DIV);

  logic [2*XW:0]  prod_r;
  logic [XW-1:0]  x_r;
  logic [XW-1:0]  q_est;
  logic [XW-1:0]  back;
  logic [XW-1:0]  rem_est;
  logic [XW-1:0]  q_nxt;
  logic [RW-1:0]  rem_nxt;
  logic [XW-1:0]  q_r;
  logic           rem_nz_r;

  // estimate is floor(x/DIV) or one below it
  always_ff @(posedge clk) begin
    if (en.ld1) begin
      prod_r <= (2*XW + 1)'(x) * (2*XW + 1)'(RECIP);
      x_r    <= x;
    end
  end

  assign q_est   = prod_r[2*XW-1:XW];
  assign back    = q_est * DIV_X;
  assign rem_est = x_r - back;

  always_comb begin
    if (rem_est >= DIV_X) begin
      q_nxt   = q_est + XW'(1);
      rem_nxt = RW'(rem_est - DIV_X);
    end else begin
      q_nxt   = q_est;
      rem_nxt = RW'(rem_est);
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      q_r      <= q_nxt;
      rem_nz_r <= (rem_nxt != '0);
    end
  end

  assign q      = q_r;
  assign rem_nz = rem_nz_r;

endmodule

// File: design/moving_average_crossover_signal.sv
// ----------------------------------------------------------------------------
// moving_average_crossover_signal
// pipeline: each transaction passes through stages a, b, c, d, e and f
// throughput: one transaction per cycle while the result side does not stall, set
//   by the read and write of the price history memory and the running sum update
// reset: synchronous, clears sums, sample count, history valid bits, pointer
//   and all pipeline valids; the history then reads as all zeros
// ----------------------------------------------------------------------------
module moving_average_crossover_signal #(
  parameter int SHORT_WINDOW = 5,
  parameter int LONG_WINDOW  = 20,
  parameter int PRICE_BITS   = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PRICE_BITS-1:0] in_close_price,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_trade_signal,
  output logic [PRICE_BITS-1:0] out_entry_price,
  output logic [PRICE_BITS:0]   out_stop_loss,
  output logic [PRICE_BITS:0]   out_take_profit,
  output logic [PRICE_BITS-1:0] out_short_average,
  output logic [PRICE_BITS-1:0] out_long_average
);

  // --------------------------------------------------------------------------
  // widths
  // --------------------------------------------------------------------------
  localparam int PB     = PRICE_BITS;
  localparam int AW     = $clog2(LONG_WINDOW);
  localparam int ENT_W  = 3 * PB;                                // {price, price^2}
  localparam int SSUM_W = PB + $clog2(SHORT_WINDOW + 1);
  localparam int LSUM_W = PB + $clog2(LONG_WINDOW + 1);
  localparam int SQ_W   = 2 * PB + $clog2(LONG_WINDOW + 1);
  localparam int CNT_W  = $clog2(LONG_WINDOW + 1);
  localparam int DW     = PB + $clog2(SHORT_WINDOW * LONG_WINDOW + 1);
  localparam int LHS_W  = 2 * DW;
  localparam int VW     = 2 * LSUM_W;
  localparam int SS     = SHORT_WINDOW * SHORT_WINDOW;
  localparam int RHS_W  = VW + $clog2(SS + 1);
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int LVL_W  = PB + 1;

  localparam logic [AW-1:0]    LAST_POS  = AW'(LONG_WINDOW - 1);
  localparam logic [AW-1:0]    SHORT_OFS = AW'(SHORT_WINDOW);
  localparam logic [AW-1:0]    WRAP_OFS  = AW'(LONG_WINDOW - SHORT_WINDOW);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(LONG_WINDOW);

  // --------------------------------------------------------------------------
  // pipeline handshake
  // stages: a (memory read data), b (running sums), c (differences),
  // d (squares), e (variance bound, levels), f (output register)
  // each stage loads when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic va_r, vb_r, vc_r, vd_r, ve_r, out_valid_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
  logic ld_a, ld_b, ld_c, ld_d, ld_e, ld_f;

  assign rdy_f = !out_valid_r || !out_stall;
  assign rdy_e = !ve_r || rdy_f;
  assign rdy_d = !vd_r || rdy_e;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;

  assign ld_a = in_valid && rdy_a;
  assign ld_b = va_r && rdy_b;
  assign ld_c = vb_r && rdy_c;
  assign ld_d = vc_r && rdy_d;
  assign ld_e = vd_r && rdy_e;
  assign ld_f = ve_r && rdy_f;

  assign in_stall  = !rdy_a;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      ve_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      va_r        <= ld_a || (va_r && !ld_b);
      vb_r        <= ld_b || (vb_r && !ld_c);
      vc_r        <= ld_c || (vc_r && !ld_d);
      vd_r        <= ld_d || (vd_r && !ld_e);
      ve_r        <= ld_e || (ve_r && !ld_f);
      out_valid_r <= ld_f || (out_valid_r && out_stall);
    end
  end

  // --------------------------------------------------------------------------
  // price history memory
  // one write and two reads per transaction, all at the write pointer edge;
  // the read at the write pointer returns the oldest price before it is
  // overwritten, so no forwarding is needed. the squared price is stored
  // alongside the price so the leaving square needs no multiplier
  // --------------------------------------------------------------------------
  logic [ENT_W-1:0]       hist_mem [LONG_WINDOW];
  logic [LONG_WINDOW-1:0] hist_vld_r;
  logic [AW-1:0]          wp_r;
  logic [AW-1:0]          wp_nxt;
  logic [AW-1:0]          sp;
  logic [2*PB-1:0]        in_psq;
  logic [ENT_W-1:0]       old_ent_r;
  logic [ENT_W-1:0]       lv_ent_r;
  logic                   old_vld_r;
  logic                   lv_vld_r;

  assign in_psq = (2*PB)'(in_close_price) * (2*PB)'(in_close_price);
  assign wp_nxt = (wp_r == LAST_POS) ? '0 : wp_r + AW'(1);
  // entry leaving the short window
  assign sp     = (wp_r >= SHORT_OFS) ? wp_r - SHORT_OFS : wp_r + WRAP_OFS;

  always_ff @(posedge clk) begin
    if (ld_a) begin
      hist_mem[wp_r] <= {in_close_price, in_psq};
      old_ent_r      <= hist_mem[wp_r];
      lv_ent_r       <= hist_mem[sp];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
      wp_r       <= '0;
      old_vld_r  <= 1'b0;
      lv_vld_r   <= 1'b0;
    end else if (ld_a) begin
      hist_vld_r[wp_r] <= 1'b1;
      wp_r             <= wp_nxt;
      old_vld_r        <= hist_vld_r[wp_r];
      lv_vld_r         <= hist_vld_r[sp];
    end
  end

  // --------------------------------------------------------------------------
  // stage a: incoming price and its square wait for the memory data
  // --------------------------------------------------------------------------
  logic [PB-1:0]   p_a_r;
  logic [2*PB-1:0] psq_a_r;
  logic [PB-1:0]   old_p;
  logic [2*PB-1:0] old_sq;
  logic [PB-1:0]   lv_p;

  always_ff @(posedge clk) begin
    if (ld_a) begin
      p_a_r   <= in_close_price;
      psq_a_r <= in_psq;
    end
  end

  assign old_p  = old_vld_r ? old_ent_r[ENT_W-1:2*PB] : '0;
  assign old_sq = old_vld_r ? old_ent_r[2*PB-1:0]     : '0;
  assign lv_p   = lv_vld_r  ? lv_ent_r[ENT_W-1:2*PB]  : '0;

  // --------------------------------------------------------------------------
  // stage b: running sums; the sum registers only change when the next
  // transaction moves in, so they double as stage b's payload
  // --------------------------------------------------------------------------
  logic [SSUM_W-1:0] short_sum_r, short_sum_nxt;
  logic [LSUM_W-1:0] long_sum_r, long_sum_nxt;
  logic [SQ_W-1:0]   sq_sum_r, sq_sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PB-1:0]     p_b_r;

  assign short_sum_nxt = short_sum_r - SSUM_W'(lv_p) + SSUM_W'(p_a_r);
  assign long_sum_nxt  = long_sum_r - LSUM_W'(old_p) + LSUM_W'(p_a_r);
  assign sq_sum_nxt    = sq_sum_r - SQ_W'(old_sq) + SQ_W'(psq_a_r);
  // sample count saturates once the long window is full
  assign cnt_nxt       = (cnt_r == FULL_CNT) ? cnt_r : cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_sum_r <= '0;
      long_sum_r  <= '0;
      sq_sum_r    <= '0;
      cnt_r       <= '0;
    end else if (ld_b) begin
      short_sum_r <= short_sum_nxt;
      long_sum_r  <= long_sum_nxt;
      sq_sum_r    <= sq_sum_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_b) begin
      p_b_r <= p_a_r;
    end
  end

  // --------------------------------------------------------------------------
  // averages and level fractions: constant dividers, loaded with stage c,
  // results line up with stage d
  // --------------------------------------------------------------------------
  macs_pkg::cdiv_en_t cd_en;
  logic [SSUM_W-1:0]  sa_q;
  logic [LSUM_W-1:0]  la_q;
  logic [PB-1:0]      q250;
  logic               r250_nz;

  assign cd_en.ld1 = ld_c;
  assign cd_en.ld2 = ld_d;

  macs_cdiv #(
    .XW  (SSUM_W),
    .DIV (SHORT_WINDOW)
  ) u_short_avg (
    .clk    (clk),
    .en     (cd_en),
    .x      (short_sum_r),
    .q      (sa_q),
    .rem_nz ()
  );

  macs_cdiv #(
    .XW  (LSUM_W),
    .DIV (LONG_WINDOW)
  ) u_long_avg (
    .clk    (clk),
    .en     (cd_en),
    .x      (long_sum_r),
    .q      (la_q),
    .rem_nz ()
  );

  macs_cdiv #(
    .XW  (PB),
    .DIV (macs_pkg::LVL_DIV)
  ) u_level (
    .clk    (clk),
    .en     (cd_en),
    .x      (p_b_r),
    .q      (q250),
    .rem_nz (r250_nz)
  );

  // --------------------------------------------------------------------------
  // stage c: scaled sums, absolute difference and direction
  // L*sum_s against S*sum_l decides direction exactly
  // --------------------------------------------------------------------------
  logic [DW-1:0]     ls, sl, d_nxt;
  logic [VW-1:0]     lsq_nxt;
  logic [DW-1:0]     d_c_r;
  logic [VW-1:0]     lsq_c_r;
  logic [LSUM_W-1:0] suml_c_r;
  logic              gt_c_r, lt_c_r, rdy_c_r;
  logic [PB-1:0]     p_c_r;

  assign ls      = DW'(short_sum_r) * DW'(LONG_WINDOW);
  assign sl      = DW'(long_sum_r) * DW'(SHORT_WINDOW);
  assign d_nxt   = (ls > sl) ? ls - sl : sl - ls;
  assign lsq_nxt = VW'(sq_sum_r) * VW'(LONG_WINDOW);

  always_ff @(posedge clk) begin
    if (ld_c) begin
      d_c_r    <= d_nxt;
      lsq_c_r  <= lsq_nxt;
      suml_c_r <= long_sum_r;
      gt_c_r   <= (ls > sl);
      lt_c_r   <= (ls < sl);
      rdy_c_r  <= (cnt_r == FULL_CNT);
      p_c_r    <= p_b_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage d: the two squares
  // --------------------------------------------------------------------------
  logic [LHS_W-1:0] lhs_d_r;
  logic [VW-1:0]    suml2_d_r;
  logic [VW-1:0]    lsq_d_r;
  logic             gt_d_r, lt_d_r, rdy_d_r;
  logic [PB-1:0]    p_d_r;

  always_ff @(posedge clk) begin
    if (ld_d) begin
      lhs_d_r   <= LHS_W'(d_c_r) * LHS_W'(d_c_r);
      suml2_d_r <= VW'(suml_c_r) * VW'(suml_c_r);
      lsq_d_r   <= lsq_c_r;
      gt_d_r    <= gt_c_r;
      lt_d_r    <= lt_c_r;
      rdy_d_r   <= rdy_c_r;
      p_d_r     <= p_c_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage e: S^2 * (L*sumsq - sum_l^2), never negative
  // levels: p*998/1000 = p - ceil(p/500), p*1004/1000 = p + floor(p/250),
  //         p*1002/1000 = p + floor(p/500), p*996/1000 = p - ceil(p/250)
  // --------------------------------------------------------------------------
  logic [VW-1:0]     var_d;
  logic [PB-1:0]     q500;
  logic              r500_nz;
  logic [RHS_W-1:0]  rhs_e_r;
  logic [LHS_W-1:0]  lhs_e_r;
  logic              gt_e_r, lt_e_r, rdy_e_r;
  logic [PB-1:0]     p_e_r;
  logic [LVL_W-1:0]  buy_sl_e_r, buy_tp_e_r, sell_sl_e_r, sell_tp_e_r;
  logic [PB-1:0]     sa_e_r, la_e_r;

  assign var_d   = lsq_d_r - suml2_d_r;
  assign q500    = q250 >> 1;
  // p mod 500 is zero only when p mod 250 is zero and p/250 is even
  assign r500_nz = r250_nz || q250[0];

  always_ff @(posedge clk) begin
    if (ld_e) begin
      rhs_e_r     <= RHS_W'(var_d) * RHS_W'(SS);
      lhs_e_r     <= lhs_d_r;
      gt_e_r      <= gt_d_r;
      lt_e_r      <= lt_d_r;
      rdy_e_r     <= rdy_d_r;
      p_e_r       <= p_d_r;
      buy_sl_e_r  <= LVL_W'(p_d_r) - LVL_W'(q500) - LVL_W'(r500_nz);
      buy_tp_e_r  <= LVL_W'(p_d_r) + LVL_W'(q250);
      sell_sl_e_r <= LVL_W'(p_d_r) + LVL_W'(q500);
      sell_tp_e_r <= LVL_W'(p_d_r) - LVL_W'(q250) - LVL_W'(r250_nz);
      sa_e_r      <= sa_q[PB-1:0];
      la_e_r      <= la_q[PB-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage f: filter compare, decision and output register
  // trades only when the short/long gap is at least one standard deviation
  // --------------------------------------------------------------------------
  logic                filt_pass;
  macs_pkg::signal_t   sig_nxt, sig_r;
  logic [LVL_W-1:0]    sl_nxt, tp_nxt;
  logic [PB-1:0]       entry_r, sa_r, la_r;
  logic [LVL_W-1:0]    sl_r, tp_r;

  assign filt_pass = CMP_W'(lhs_e_r) >= CMP_W'(rhs_e_r);

  always_comb begin
    if (!rdy_e_r) begin
      sig_nxt = macs_pkg::SIG_NOT_READY;
    end else if (filt_pass && gt_e_r) begin
      sig_nxt = macs_pkg::SIG_BUY;
    end else if (filt_pass && lt_e_r) begin
      sig_nxt = macs_pkg::SIG_SELL;
    end else begin
      sig_nxt = macs_pkg::SIG_HOLD;
    end
  end

  always_comb begin
    case (sig_nxt)
      macs_pkg::SIG_BUY: begin
        sl_nxt = buy_sl_e_r;
        tp_nxt = buy_tp_e_r;
      end
      macs_pkg::SIG_SELL: begin
        sl_nxt = sell_sl_e_r;
        tp_nxt = sell_tp_e_r;
      end
      default: begin
        sl_nxt = '0;
        tp_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_f) begin
      sig_r   <= sig_nxt;
      entry_r <= p_e_r;
      sl_r    <= sl_nxt;
      tp_r    <= tp_nxt;
      sa_r    <= rdy_e_r ? sa_e_r : '0;
      la_r    <= rdy_e_r ? la_e_r : '0;
    end
  end

  assign out_trade_signal  = sig_r;
  assign out_entry_price   = entry_r;
  assign out_stop_loss     = sl_r;
  assign out_take_profit   = tp_r;
  assign out_short_average = sa_r;
  assign out_long_average  = la_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // an empty first stage never stalls the input
  assert property (@(posedge clk) disable iff (!rst_n) !va_r |-> !in_stall)
    else $error("input stalled with empty first stage");

  // sample count saturates at the long window
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= FULL_CNT)
    else $error("sample count past long window");

  // a full window implies every history entry was written
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == FULL_CNT) |-> (&hist_vld_r))
    else $error("history entry unwritten after window filled");

  // no levels without a trade
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_trade_signal == macs_pkg::SIG_NOT_READY ||
                   out_trade_signal == macs_pkg::SIG_HOLD))
    |-> (out_stop_loss == '0 && out_take_profit == '0))
    else $error("levels given without a trade");

  // buy levels bracket the entry price
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_trade_signal == macs_pkg::SIG_BUY)
    |-> (out_stop_loss <= LVL_W'(out_entry_price) &&
         out_take_profit >= LVL_W'(out_entry_price)))
    else $error("buy levels on wrong side of entry");

  // sell levels bracket the entry price
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_trade_signal == macs_pkg::SIG_SELL)
    |-> (out_stop_loss >= LVL_W'(out_entry_price) &&
         out_take_profit <= LVL_W'(out_entry_price)))
    else $error("sell levels on wrong side of entry");
`endif

endmodule

// File: verif/moving_average_crossover_signal_tb.sv
// ----------------------------------------------------------------------------
// moving_average_crossover_signal_tb
// self-checking bench for the crossover signal block: a directed table that
// fills the window and hits the extremes, then trending, flat and noisy price
// series with random gaps and stalls, each result compared against its typed
// table row or an in-bench model of the running sums and the volatility filter
// ----------------------------------------------------------------------------
module moving_average_crossover_signal_tb;

  localparam int SHORT_LEN = 5;
  localparam int LONG_LEN  = 20;
  localparam int PRICE_W   = 24;
  localparam int PRICE_MAX = (1 << PRICE_W) - 1;

  // level ratios in per mille
  localparam int PERMIL          = 1000;
  localparam int BUY_STOP_PERMIL = 998;
  localparam int BUY_TAKE_PERMIL = 1004;
  localparam int SEL_STOP_PERMIL = 1002;
  localparam int SEL_TAKE_PERMIL = 996;

  localparam int RANDOM_ITEMS = 525;

  // one result transaction
  typedef struct {
    macs_pkg::signal_t    sig;
    logic [PRICE_W-1:0]   entry;
    logic [PRICE_W:0]     stop;
    logic [PRICE_W:0]     target;
    logic [PRICE_W-1:0]   avg_s;
    logic [PRICE_W-1:0]   avg_l;
  } trade_t;

  // directed row; typed rows carry their result, the others use the model
  typedef struct {
    logic [PRICE_W-1:0] price;
    bit                 typed;
    macs_pkg::signal_t  sig;
    logic [PRICE_W-1:0] avg_s;
    logic [PRICE_W-1:0] avg_l;
  } dir_row_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [PRICE_W-1:0]   in_close_price = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic [1:0]           out_trade_signal;
  logic [PRICE_W-1:0]   out_entry_price;
  logic [PRICE_W:0]     out_stop_loss;
  logic [PRICE_W:0]     out_take_profit;
  logic [PRICE_W-1:0]   out_short_average;
  logic [PRICE_W-1:0]   out_long_average;

  // model state: delay line, write pointer, running sums, fill count
  logic [PRICE_W-1:0]   hist [LONG_LEN];
  int unsigned          wr_ptr    = 0;
  logic [26:0]          sum_short = '0;
  logic [28:0]          sum_long  = '0;
  logic [52:0]          sum_sq    = '0;
  int unsigned          n_seen    = 0;

  trade_t               pending_trades [$];

  bit                   idle_en    = 1'b1;
  int                   stall_left = 0;
  int                   n_errors   = 0;
  int                   n_results  = 0;
  int                   n_sent     = 0;
  int                   sig_count [4] = '{0, 0, 0, 0};

  // directed part: four odd prices, then max prices until the window is all
  // max, which must read as hold with both averages at full scale; then a
  // drop to zero
  dir_row_t dir_table [25] = '{
    '{24'h000000, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hAAAAAA, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'h555555, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'h000001, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_NOT_READY, 24'h000000, 24'h000000},
    // first full windows, still holding the odd prices
    '{24'hFFFFFF, 1'b0, macs_pkg::SIG_HOLD,      24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b0, macs_pkg::SIG_HOLD,      24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b0, macs_pkg::SIG_HOLD,      24'h000000, 24'h000000},
    '{24'hFFFFFF, 1'b0, macs_pkg::SIG_HOLD,      24'h000000, 24'h000000},
    // all twenty at max: equal averages, zero variance
    '{24'hFFFFFF, 1'b1, macs_pkg::SIG_HOLD,      24'hFFFFFF, 24'hFFFFFF},
    '{24'h000000, 1'b0, macs_pkg::SIG_HOLD,      24'h000000, 24'h000000}
  };

  moving_average_crossover_signal #(
    .SHORT_WINDOW (SHORT_LEN),
    .LONG_WINDOW  (LONG_LEN),
    .PRICE_BITS   (PRICE_W)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_close_price    (in_close_price),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trade_signal  (out_trade_signal),
    .out_entry_price   (out_entry_price),
    .out_stop_loss     (out_stop_loss),
    .out_take_profit   (out_take_profit),
    .out_short_average (out_short_average),
    .out_long_average  (out_long_average)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mostly none, often short, now and then long
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // append one expectation at the tail of the scoreboard queue
  function automatic void queue_trade(trade_t t);
    pending_trades.insert(pending_trades.size(), t);
  endfunction

  // advance the model by one price and work out the trade it causes
  function automatic trade_t predict_trade(logic [PRICE_W-1:0] price);
    trade_t             t;
    logic [PRICE_W-1:0] oldest;
    logic [PRICE_W-1:0] leaving;
    logic [127:0]       ls;
    logic [127:0]       sl;
    logic [127:0]       diff;
    logic [127:0]       lhs;
    logic [127:0]       var_l;
    logic [127:0]       rhs;
    logic [63:0]        p_ext;
    oldest    = hist[wr_ptr];
    leaving   = hist[(wr_ptr + LONG_LEN - SHORT_LEN) % LONG_LEN];
    sum_short = sum_short - 27'(leaving) + 27'(price);
    sum_long  = sum_long - 29'(oldest) + 29'(price);
    sum_sq    = sum_sq - 53'(oldest) * 53'(oldest) + 53'(price) * 53'(price);
    hist[wr_ptr] = price;
    wr_ptr = (wr_ptr + 1) % LONG_LEN;
    if (n_seen < LONG_LEN) n_seen++;

    t.sig    = macs_pkg::SIG_NOT_READY;
    t.entry  = price;
    t.stop   = '0;
    t.target = '0;
    t.avg_s  = '0;
    t.avg_l  = '0;
    if (n_seen >= LONG_LEN) begin
      // exact filter: squared average gap against scaled variance, no root
      ls    = 128'(sum_short) * 128'(LONG_LEN);
      sl    = 128'(sum_long) * 128'(SHORT_LEN);
      diff  = (ls >= sl) ? ls - sl : sl - ls;
      lhs   = diff * diff;
      var_l = 128'(sum_sq) * 128'(LONG_LEN) - 128'(sum_long) * 128'(sum_long);
      rhs   = var_l * 128'(SHORT_LEN * SHORT_LEN);
      t.avg_s = PRICE_W'(sum_short / SHORT_LEN);
      t.avg_l = PRICE_W'(sum_long / LONG_LEN);
      t.sig   = macs_pkg::SIG_HOLD;
      p_ext   = 64'(price);
      // direction from the exact sums, equal sums stay on hold
      if (lhs >= rhs) begin
        if (ls > sl) begin
          t.sig    = macs_pkg::SIG_BUY;
          t.stop   = (PRICE_W + 1)'((p_ext * BUY_STOP_PERMIL) / PERMIL);
          t.target = (PRICE_W + 1)'((p_ext * BUY_TAKE_PERMIL) / PERMIL);
        end else if (ls < sl) begin
          t.sig    = macs_pkg::SIG_SELL;
          t.stop   = (PRICE_W + 1)'((p_ext * SEL_STOP_PERMIL) / PERMIL);
          t.target = (PRICE_W + 1)'((p_ext * SEL_TAKE_PERMIL) / PERMIL);
        end
      end
    end
    return t;
  endfunction

  // present one price, hold it until taken, then advance the model
  task automatic send_price(input logic [PRICE_W-1:0] price, output trade_t predicted);
    in_valid       <= 1'b1;
    in_close_price <= price;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = predict_trade(price);
    n_sent++;
  endtask

  // optional gap on the input side before the next transaction
  task automatic idle_gap();
    int gap;
    gap = idle_en ? pick_idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_trades.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result side stall generator, off during the full-rate stretch
  always @(posedge clk) begin
    int len;
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      len = idle_en ? pick_idle_len() : 0;
      out_stall  <= (len > 0);
      stall_left <= (len > 0) ? len - 1 : 0;
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    trade_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_trades.size() == 0) begin
        n_errors++;
        $display("%0t: result expected none actual signal %0d price %0h",
                 $time, out_trade_signal, out_entry_price);
      end else begin
        want = pending_trades.pop_front();
        sig_count[want.sig]++;
        n_results++;
        check_field("trade_signal",  32'(want.sig),    32'(out_trade_signal));
        check_field("entry_price",   32'(want.entry),  32'(out_entry_price));
        check_field("stop_loss",     32'(want.stop),   32'(out_stop_loss));
        check_field("take_profit",   32'(want.target), 32'(out_take_profit));
        check_field("short_average", 32'(want.avg_s),  32'(out_short_average));
        check_field("long_average",  32'(want.avg_l),  32'(out_long_average));
      end
    end
  end

  initial begin : stimulus
    trade_t             predicted;
    trade_t             typed_trade;
    logic [PRICE_W-1:0] price;
    int                 n_random;
    int                 kind;
    int                 seg_len;
    int                 level;
    int                 drift;
    int                 jit_span;
    foreach (hist[i]) hist[i] = '0;
    n_random = 0;
    level    = $urandom_range(0, PRICE_MAX);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_table[i]) begin
      idle_gap();
      send_price(dir_table[i].price, predicted);
      if (dir_table[i].typed) begin
        typed_trade.sig    = dir_table[i].sig;
        typed_trade.entry  = dir_table[i].price;
        typed_trade.stop   = '0;
        typed_trade.target = '0;
        typed_trade.avg_s  = dir_table[i].avg_s;
        typed_trade.avg_l  = dir_table[i].avg_l;
        queue_trade(typed_trade);
      end else begin
        queue_trade(predicted);
      end
    end

    // random series: mostly trends that pull the short average away from
    // the long one, some flat runs, some raw noise
    while (n_random < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        seg_len = $urandom_range(1, 4);
      end else if (kind == 1) begin
        seg_len = $urandom_range(5, 25);
      end else begin
        seg_len  = $urandom_range(8, 40);
        drift    = 1 << $urandom_range(4, 18);
        if ($urandom_range(0, 1)) drift = -drift;
        jit_span = 1 << $urandom_range(0, 12);
      end
      for (int k = 0; k < seg_len && n_random < RANDOM_ITEMS; k++) begin
        // sender pauses to let the pipeline empty; the middle stretch
        // runs at full rate with no gaps and no stalls
        if (n_random == 200 || n_random == 330) begin
          drain_results();
          idle_en = (n_random == 330);
        end
        case (kind)
          0: begin
            price = PRICE_W'($urandom);
            level = int'(price);
          end
          1: price = PRICE_W'(level);
          default: begin
            level = level + drift + int'($urandom_range(0, 2 * jit_span)) - jit_span;
            if (level < 0) level = 0;
            else if (level > PRICE_MAX) level = PRICE_MAX;
            price = PRICE_W'(level);
          end
        endcase
        idle_gap();
        send_price(price, predicted);
        queue_trade(predicted);
        n_random++;
      end
    end

    drain_results();
    repeat (12) @(posedge clk);

    $display("covered %0d price transactions, %0d results checked in order",
             n_sent, n_results);
    $display("signals seen: %0d not ready, %0d hold, %0d buy, %0d sell",
             sig_count[macs_pkg::SIG_NOT_READY], sig_count[macs_pkg::SIG_HOLD],
             sig_count[macs_pkg::SIG_BUY], sig_count[macs_pkg::SIG_SELL]);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
